@@ rtl/cdcw_pkg.sv @@
`default_nettype none

package cdcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 16;
	localparam int ROWS    = 2;
	localparam int COL_W   = 4;
	localparam int ROW_W   = 1;
	localparam int ADDR_W  = ROW_W + COL_W;
	localparam int DEPTH   = ROWS * COLUMNS;

	// Display controller bytes and special characters
	localparam logic [7:0] BYTE_CLEAR    = 8'h01;
	localparam logic [7:0] BYTE_SET_ADDR = 8'h80;
	localparam logic [7:0] ROW1_START    = 8'h40;
	localparam logic [7:0] CH_CR         = 8'd13;
	localparam logic [7:0] CH_LF         = 8'd10;
	localparam logic [7:0] CH_SPACE      = 8'h20;

	// Emitted byte kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	// Configuration register indexes
	localparam logic REG_PRESENT   = 1'b0;
	localparam logic REG_BACKLIGHT = 1'b1;

	typedef enum logic [2:0] {
		CMD_PUT   = 3'd0,
		CMD_HOME  = 3'd1,
		CMD_ROW   = 3'd2,
		CMD_COL   = 3'd3,
		CMD_CLEAR = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	// Read, write and clear request to the screen store
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              clr;
	} store_req_t;

	// One result item, without the backlight level
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       emit_byte;
		logic             last;
		logic [7:0]       read_char;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/char_display_cursor_writer_top.sv @@
// Text front end for a two-row, sixteen-column character display. Each input item
// carries a command (put char, home, set row, set column, clear, read char) and
// yields one result item, or two when a printable character follows a cursor move:
// a set-address command byte, then the data byte; m_tlast marks the final one.
// An item passes the accept state, which starts a registered read of the 32-entry
// screen store, and an execute state that uses the read data, updates the cursor
// and writes the store back when the output register is free; the second byte of a
// put char adds a third state. Clear resets the whole store at once through per-entry
// valid bits. The output register lets the next item in while a result still waits;
// bytes are emitted only while present is 1, and backlight_level follows the register.
`default_nettype none

module char_display_cursor_writer_top
	import cdcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // char_code, row_value, col_value
	input  wire logic [2:0]  s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // emit_byte, read_char, cursor_row,
	                                   // cursor_col, backlight_level, zero pad
	output logic [1:0]       m_tuser,  // emit_kind
	output logic             m_tlast,  // last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data
);

	logic       present_q;
	logic       backlight_q;
	logic       out_free;
	logic       out_load;
	res_t       out_res;
	store_req_t req;
	logic [7:0] rd_char;
	logic       m_valid_q;
	res_t       m_res_q;
	logic       m_bl_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= 1'b1;
			backlight_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRESENT:   present_q   <= cfg_data;
				REG_BACKLIGHT: backlight_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cdcw_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_char (rd_char)
	);

	cdcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.present  (present_q),
		.out_free (out_free),
		.out_load (out_load),
		.out_res  (out_res),
		.req      (req),
		.rd_char  (rd_char)
	);

	// Output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_res_q <= out_res;
			m_bl_q  <= backlight_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.kind;
	assign m_tlast  = m_res_q.last;
	assign m_tdata  = {2'b00, m_bl_q, m_res_q.col, m_res_q.row,
		m_res_q.read_char, m_res_q.emit_byte};

endmodule

`default_nettype wire

@@ rtl/cdcw_store.sv @@
`default_nettype none

module cdcw_store
	import cdcw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	output logic [7:0]      rd_char
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_data_s1;
	logic             rd_valid_s1;

	// Write port of the character array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read of data and its valid bit
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_s1  <= mem[req.rd_addr];
			rd_valid_s1 <= valid_q[req.rd_addr];
		end
	end

	// Mark written entries; clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// An entry never written since reset or the last clear reads as a space
	assign rd_char = rd_valid_s1 ? rd_data_s1 : CH_SPACE;

endmodule

`default_nettype wire

@@ rtl/cdcw_ctrl.sv @@
`default_nettype none

module cdcw_ctrl
	import cdcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        present,
	input  wire logic        out_free,
	output logic             out_load,
	output res_t             out_res,
	output store_req_t       req,
	input  wire logic [7:0]  rd_char
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_SECOND = 3'b100
	} state_t;

	state_t           state_q;
	logic             accept;
	logic [2:0]       cmd_s1;
	logic [7:0]       ch_s1;
	logic [ROW_W-1:0] rv_s1;
	logic [COL_W-1:0] cv_s1;

	logic [ROW_W-1:0] row_q, row_n;
	logic [COL_W-1:0] col_q, col_n;
	logic             flag_q, flag_n;
	logic [COL_W:0]   col_inc;
	logic             wr, clr, two;
	res_t             r0, r1, pend_q;
	logic             commit;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign col_inc  = {1'b0, col_q} + 1'b1;

	// Hold the accepted item; row and column are taken modulo the geometry
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= s_tuser;
			ch_s1  <= s_tdata[7:0];
			rv_s1  <= s_tdata[8 +: ROW_W];
			cv_s1  <= s_tdata[16 +: COL_W];
		end
	end

	// Work out the new cursor and the results of the held item
	always_comb begin
		row_n = row_q;
		col_n = col_q;
		flag_n = flag_q;
		wr = 1'b0;
		clr = 1'b0;
		two = 1'b0;
		r0 = '0;
		r1 = '0;
		r0.kind = KIND_NONE;
		r0.last = 1'b1;
		r1.kind = KIND_DATA;
		r1.emit_byte = ch_s1;
		r1.last = 1'b1;
		case (cmd_t'(cmd_s1))
			CMD_PUT: begin
				if (ch_s1 == CH_CR) begin
					col_n = '0;
					flag_n = 1'b1;
				end else if (ch_s1 == CH_LF) begin
					// Row advance wraps through the row counter's width
					col_n = '0;
					row_n = row_q + 1'b1;
					flag_n = 1'b1;
				end else begin
					wr = 1'b1;
					flag_n = 1'b0;
					if (col_inc >= (COL_W+1)'(COLUMNS)) begin
						col_n = '0;
						row_n = row_q + 1'b1;
						flag_n = 1'b1;
					end else begin
						col_n = col_inc[COL_W-1:0];
					end
					if (present) begin
						if (flag_q) begin
							two = 1'b1;
							r0.kind = KIND_CMD;
							r0.emit_byte = BYTE_SET_ADDR | (row_q[0] ? ROW1_START : 8'h00)
								| {{(8-COL_W){1'b0}}, col_q};
							r0.last = 1'b0;
						end else begin
							r0.kind = KIND_DATA;
							r0.emit_byte = ch_s1;
						end
					end
				end
			end
			CMD_HOME: begin
				row_n = '0;
				col_n = '0;
				flag_n = 1'b1;
			end
			CMD_ROW: begin
				row_n = rv_s1;
				flag_n = 1'b1;
			end
			CMD_COL: begin
				col_n = cv_s1;
				flag_n = 1'b1;
			end
			CMD_CLEAR: begin
				clr = 1'b1;
				row_n = '0;
				col_n = '0;
				flag_n = 1'b0;
				if (present) begin
					r0.kind = KIND_CMD;
					r0.emit_byte = BYTE_CLEAR;
				end
			end
			CMD_READ: begin
				r0.read_char = rd_char;
			end
			default: begin
			end
		endcase
		r0.row = row_n;
		r0.col = col_n;
		r1.row = row_n;
		r1.col = col_n;
	end

	assign commit = (state_q == S_EXEC) && out_free;

	// Read at accept, write back and clear when the item commits
	always_comb begin
		req.rd_en   = accept;
		req.rd_addr = {s_tdata[8 +: ROW_W], s_tdata[16 +: COL_W]};
		req.wr_en   = commit && wr;
		req.wr_addr = {row_q, col_q};
		req.wr_data = ch_s1;
		req.clr     = commit && clr;
	end

	// Load the output stage with the first or the pending second result
	always_comb begin
		out_load = 1'b0;
		out_res  = r0;
		case (state_q)
			S_EXEC: begin
				out_load = out_free;
			end
			S_SECOND: begin
				out_load = out_free;
				out_res  = pend_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pend_q <= r1;
		end
	end

	// Sequence and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			flag_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						row_q   <= row_n;
						col_q   <= col_n;
						flag_q  <= flag_n;
						state_q <= two ? S_SECOND : S_IDLE;
					end
				end
				S_SECOND: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/cdcw_checker.sv @@
`default_nettype none

module cdcw_checker
	import cdcw_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// Refuse a new item straight after one is accepted
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while previous one in work");

	// Only a set-address command precedes another result of the same item
	a_first_is_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == KIND_CMD && m_tdata[7] == 1'b1)
		else $error("non-final result is not a set-address command");

	// Follow the set-address command at once with the final data byte
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && m_tuser == KIND_DATA)
		else $error("data byte does not follow set-address command");

	// Send no byte value with an empty result
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tdata[7:0] == 8'h00)
		else $error("byte value on a result with nothing sent");

endmodule

bind char_display_cursor_writer_top cdcw_checker u_chk (.*);

`default_nettype wire
